// ----- hw/rtl/dtpw_pkg.sv -----
package dtpw_pkg;

	// operation codes
	localparam logic [1:0] OP_WRITE = 2'd0;
	localparam logic [1:0] OP_READ  = 2'd1;
	localparam logic [1:0] OP_CLEAR = 2'd2;

	// configuration register indexes
	localparam int          REG_IDX_W       = 3;
	localparam logic [2:0]  REG_VIEWPORT_X  = 3'd0;
	localparam logic [2:0]  REG_VIEWPORT_Y  = 3'd1;
	localparam logic [2:0]  REG_VIEWPORT_W  = 3'd2;
	localparam logic [2:0]  REG_VIEWPORT_H  = 3'd3;
	localparam logic [2:0]  REG_DEPTH_TEST  = 3'd4;
	localparam int          REG_DATA_W      = 11;

	// field widths
	localparam int COORD_W = 11;
	localparam int DEPTH_W = 18;
	localparam int CHAN_W  = 8;
	localparam int COLOR_W = 3 * CHAN_W;

	// far plane, 1.0 in Q.16
	localparam logic signed [DEPTH_W-1:0] DEPTH_FAR = 18'sd65536;

	typedef logic signed [DEPTH_W-1:0] depth_t;
	typedef logic [COLOR_W-1:0]        color_t;

endpackage

// ----- hw/rtl/dtpw_frag_if.sv -----
interface dtpw_frag_if import dtpw_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic [1:0]                op;
	logic signed [COORD_W-1:0] x_coord;
	logic signed [COORD_W-1:0] y_coord;
	depth_t                    frag_depth;
	logic [CHAN_W-1:0]         red_in;
	logic [CHAN_W-1:0]         green_in;
	logic [CHAN_W-1:0]         blue_in;

	modport source (output valid, op, x_coord, y_coord, frag_depth, red_in, green_in,
		blue_in, input ready);
	modport sink (input valid, op, x_coord, y_coord, frag_depth, red_in, green_in,
		blue_in, output ready);
endinterface

// ----- hw/rtl/dtpw_res_if.sv -----
interface dtpw_res_if import dtpw_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              written;
	logic [CHAN_W-1:0] red_out;
	logic [CHAN_W-1:0] green_out;
	logic [CHAN_W-1:0] blue_out;

	modport source (output valid, written, red_out, green_out, blue_out, input ready);
	modport sink (input valid, written, red_out, green_out, blue_out, output ready);
endinterface

// ----- hw/rtl/depth_tested_pixel_write.sv -----
// Channel   Dir  Handshake     Word
// -------   ---  ---------     ----
// frag      in   valid/ready   op, x_coord, y_coord, frag_depth, red_in, green_in, blue_in
// res       out  valid/ready   written, red_out, green_out, blue_out
// cfg_*     in   cfg_we        cfg_idx selects register, cfg_wdata carries value
//
// Each word passes through accept (address multiply and viewport test), RAM read,
// then compare and write back into the single port of each RAM; the next word is taken after write-back.
// After reset the depth RAM is swept to far, one pixel per cycle, and
// frag.ready stays low until the sweep ends.
// A result waits in the output register; while it is not taken the block still
// accepts and reads the next word, and holds before writing back.
module depth_tested_pixel_write import dtpw_pkg::*; #(
	parameter int SCREEN_W = 640,
	parameter int SCREEN_H = 480
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [REG_IDX_W-1:0]  cfg_idx,
	input  logic [REG_DATA_W-1:0] cfg_wdata,
	dtpw_frag_if.sink             frag,
	dtpw_res_if.source            res
);
	localparam int PIXELS = SCREEN_W * SCREEN_H;
	localparam int AW     = PIXELS > 1 ? $clog2(PIXELS) : 1;
	localparam int LIN_W  = 21;

	// sequencer states
	localparam logic [1:0] ST_CLR  = 2'd0;
	localparam logic [1:0] ST_IDLE = 2'd1;
	localparam logic [1:0] ST_RD   = 2'd2;
	localparam logic [1:0] ST_EX   = 2'd3;

	logic [1:0] st_q;

	// configuration
	logic [9:0]  vp_x_q;
	logic [9:0]  vp_y_q;
	logic [10:0] vp_w_q;
	logic [10:0] vp_h_q;
	logic        dte_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vp_x_q <= '0;
			vp_y_q <= '0;
			vp_w_q <= 11'd640;
			vp_h_q <= 11'd480;
			dte_q  <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_VIEWPORT_X: vp_x_q <= cfg_wdata[9:0];
				REG_VIEWPORT_Y: vp_y_q <= cfg_wdata[9:0];
				REG_VIEWPORT_W: vp_w_q <= cfg_wdata;
				REG_VIEWPORT_H: vp_h_q <= cfg_wdata;
				REG_DEPTH_TEST: dte_q  <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	// accept stage: screen and viewport tests, linear address
	logic             acc;
	logic             on_scr;
	logic             in_vp;
	logic [11:0]      xu;
	logic [11:0]      yu;
	logic [LIN_W-1:0] lin;

	assign acc = frag.valid && frag.ready;
	assign xu  = {2'b00, frag.x_coord[9:0]};
	assign yu  = {2'b00, frag.y_coord[9:0]};
	assign on_scr = !frag.x_coord[COORD_W-1] && !frag.y_coord[COORD_W-1]
		&& (xu < 12'(SCREEN_W)) && (yu < 12'(SCREEN_H));
	assign in_vp = (xu >= {2'b00, vp_x_q}) && (xu < ({2'b00, vp_x_q} + {1'b0, vp_w_q}))
		&& (yu >= {2'b00, vp_y_q}) && (yu < ({2'b00, vp_y_q} + {1'b0, vp_h_q}));
	assign lin = LIN_W'(frag.y_coord[9:0]) * LIN_W'(SCREEN_W) + LIN_W'(frag.x_coord[9:0]);

	logic [AW-1:0]     addr_q;
	logic [1:0]        op_q;
	logic              on_q;
	logic              pass_q;       // on screen and inside viewport
	depth_t            z_q;
	color_t            rgb_q;
	logic [AW-1:0]     clr_q;

	always_ff @(posedge clk) begin
		if (acc) begin
			addr_q <= lin[AW-1:0];
			op_q   <= frag.op;
			on_q   <= on_scr;
			pass_q <= on_scr && in_vp;
			z_q    <= frag.frag_depth;
			rgb_q  <= {frag.red_in, frag.green_in, frag.blue_in};
		end
	end

	// RAMs
	logic    ram_re;
	logic    col_we;
	logic    dep_we;
	depth_t  dep_wdata;
	depth_t  dep_rdata;
	color_t  col_rdata;
	logic    [AW-1:0] dep_addr;

	logic go;            // write-back may proceed, output register free
	logic ztest_ok;
	logic frag_ok;

	assign ram_re   = (st_q == ST_RD);
	assign go       = (st_q == ST_EX) && (!res.valid || res.ready);
	assign ztest_ok = !dte_q || (z_q < dep_rdata);
	assign frag_ok  = pass_q && ztest_ok;

	assign col_we    = go && (op_q == OP_WRITE) && frag_ok;
	assign dep_we    = (st_q == ST_CLR)
		|| (go && (((op_q == OP_WRITE) && frag_ok && dte_q) || ((op_q == OP_CLEAR) && on_q)));
	assign dep_wdata = ((st_q == ST_CLR) || (op_q == OP_CLEAR)) ? DEPTH_FAR : z_q;
	assign dep_addr  = (st_q == ST_CLR) ? clr_q : addr_q;

	dtpw_ram #(.WIDTH(COLOR_W), .DEPTH(PIXELS)) u_color_ram (
		.clk   (clk),
		.we    (col_we),
		.re    (ram_re),
		.addr  (addr_q),
		.wdata (rgb_q),
		.rdata (col_rdata)
	);

	dtpw_ram #(.WIDTH(DEPTH_W), .DEPTH(PIXELS)) u_depth_ram (
		.clk   (clk),
		.we    (dep_we),
		.re    (ram_re),
		.addr  (dep_addr),
		.wdata (dep_wdata),
		.rdata (dep_rdata)
	);

	// sequencer and clear sweep
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= ST_CLR;
			clr_q <= '0;
		end else begin
			case (st_q)
				ST_CLR: begin
					if (clr_q == AW'(PIXELS - 1)) begin
						st_q <= ST_IDLE;
					end else begin
						clr_q <= clr_q + 1'b1;
					end
				end
				ST_IDLE: begin
					if (acc) st_q <= ST_RD;
				end
				ST_RD: st_q <= ST_EX;
				ST_EX: begin
					if (go) st_q <= ST_IDLE;
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	assign frag.ready = (st_q == ST_IDLE);

	// output register
	logic              res_vld_q;
	logic              written_q;
	logic [CHAN_W-1:0] red_q;
	logic [CHAN_W-1:0] green_q;
	logic [CHAN_W-1:0] blue_q;
	logic              rd_hit;

	assign rd_hit = (op_q == OP_READ) && on_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_vld_q <= 1'b0;
		end else if (go) begin
			res_vld_q <= 1'b1;
		end else if (res.ready) begin
			res_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			written_q <= col_we || ((op_q == OP_CLEAR) && on_q);
			red_q     <= rd_hit ? col_rdata[23:16] : '0;
			green_q   <= rd_hit ? col_rdata[15:8]  : '0;
			blue_q    <= rd_hit ? col_rdata[7:0]   : '0;
		end
	end

	assign res.valid     = res_vld_q;
	assign res.written   = written_q;
	assign res.red_out   = red_q;
	assign res.green_out = green_q;
	assign res.blue_out  = blue_q;

	// checks
	a_no_accept_in_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_CLR) |-> (!frag.ready && !col_we))
		else $error("word accepted or color written during depth sweep");

	a_result_from_ex: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res.valid) |-> ($past(st_q) == ST_EX))
		else $error("result appeared without write-back step");

	a_color_write_reported: assert property (@(posedge clk) disable iff (!arst_n)
		col_we |=> (res.valid && res.written))
		else $error("color write not reported as written");

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_RD) |=> (st_q == ST_EX))
		else $error("read step not followed by write-back step");
endmodule

// ----- hw/rtl/dtpw_ram.sv -----
module dtpw_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                       clk,
	input  logic                                       we,
	input  logic                                       re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] addr,
	input  logic [WIDTH-1:0]                           wdata,
	output logic [WIDTH-1:0]                           rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem[addr];
		end
	end
endmodule

// ----- verif/depth_tested_pixel_write_test.sv -----
`timescale 1ns / 1ps

module depth_tested_pixel_write_test;
	import dtpw_pkg::*;

	localparam int SCREEN_W = 640;
	localparam int SCREEN_H = 480;

	// op 3 has no function; the block must answer it with an all-zero word
	localparam logic [1:0] OP_UNUSED = 2'd3;

	// no word moves on either channel for this many cycles -> hung.
	// Covers the depth RAM sweep after reset (one pixel per cycle) with margin.
	localparam int STALL_LIMIT = 1250000;
	// cycles the output side refuses words during the backpressure test
	localparam int HOLD_CYCLES = 400;
	// settle time after the last result, a few times the 3-stage pipe
	localparam int SETTLE_CYCLES = 12;
	localparam int HOT_N = 8;

	typedef struct packed {
		logic [1:0]                op;
		logic signed [COORD_W-1:0] x_coord;
		logic signed [COORD_W-1:0] y_coord;
		depth_t                    frag_depth;
		logic [CHAN_W-1:0]         red;
		logic [CHAN_W-1:0]         green;
		logic [CHAN_W-1:0]         blue;
	} frag_word_t;

	typedef struct packed {
		logic              written;
		logic [CHAN_W-1:0] red;
		logic [CHAN_W-1:0] green;
		logic [CHAN_W-1:0] blue;
	} pixel_result_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [REG_IDX_W-1:0]  cfg_idx;
	logic [REG_DATA_W-1:0] cfg_wdata;

	dtpw_frag_if frag_ch ();
	dtpw_res_if  res_ch ();

	depth_tested_pixel_write #(
		.SCREEN_W (SCREEN_W),
		.SCREEN_H (SCREEN_H)
	) u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.frag      (frag_ch),
		.res       (res_ch)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// ---------------------------------------------------------------
	// Predicted frame buffer and register copy.
	// Depth entries that were never touched read as far; colour entries
	// that were never written are never read (reads are steered away).
	// ---------------------------------------------------------------
	int     vp_x, vp_y, vp_w, vp_h;
	bit     depth_on;
	color_t color_mem [int];
	depth_t depth_mem [int];
	int     written_px [$];   // pixel indexes with a defined colour

	pixel_result_t due_results [$];
	int            fail_count;

	// on-screen viewport pixels (whole screen if none), hit often so that writes land,
	// depth tests fight each other and back-to-back same-pixel hazards occur
	int hot_x [HOT_N];
	int hot_y [HOT_N];

	// sender burst state, receiver long-hold request (toggle handshake)
	int burst_left;
	bit hold_tog;

	function automatic bit on_screen(int x, int y);
		return x >= 0 && y >= 0 && x < SCREEN_W && y < SCREEN_H;
	endfunction

	// Applies one word to the predicted frame buffer and returns the answer
	function automatic pixel_result_t apply_pixel_op(frag_word_t w);
		pixel_result_t r;
		int            x, y, idx;
		bit            on;
		depth_t        stored;
		color_t        c;

		r   = '0;
		x   = $signed(w.x_coord);
		y   = $signed(w.y_coord);
		on  = on_screen(x, y);
		idx = on ? y * SCREEN_W + x : 0;
		case (w.op)
			OP_WRITE: begin
				if (on && x >= vp_x && x < vp_x + vp_w && y >= vp_y && y < vp_y + vp_h) begin
					stored = depth_mem.exists(idx) ? depth_mem[idx] : DEPTH_FAR;
					// strict less-than wins; equal depth is dropped
					if (!depth_on || w.frag_depth < stored) begin
						if (!color_mem.exists(idx))
							written_px = {written_px, idx};
						color_mem[idx] = {w.red, w.green, w.blue};
						if (depth_on)
							depth_mem[idx] = w.frag_depth;
						r.written = 1'b1;
					end
				end
			end
			OP_READ: begin
				if (on && color_mem.exists(idx)) begin
					c       = color_mem[idx];
					r.red   = c[23:16];
					r.green = c[15:8];
					r.blue  = c[7:0];
				end
			end
			OP_CLEAR: begin
				// ignores viewport and depth test enable
				if (on) begin
					depth_mem[idx] = DEPTH_FAR;
					r.written      = 1'b1;
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	function automatic frag_word_t make_word(logic [1:0] op, int x, int y, int z,
			int r, int g, int b);
		frag_word_t w;
		w.op         = op;
		w.x_coord    = COORD_W'(x);
		w.y_coord    = COORD_W'(y);
		w.frag_depth = DEPTH_W'(z);
		w.red        = CHAN_W'(r);
		w.green      = CHAN_W'(g);
		w.blue       = CHAN_W'(b);
		return w;
	endfunction

	function automatic frag_word_t random_word();
		logic [1:0] op;
		int         pick, k, x, y, z;

		pick = $urandom_range(0, 99);
		op   = pick < 55 ? OP_WRITE : pick < 75 ? OP_READ : pick < 92 ? OP_CLEAR : OP_UNUSED;

		pick = $urandom_range(0, 99);
		if (pick < 65) begin
			k = $urandom_range(0, HOT_N - 1);
			x = hot_x[k];
			y = hot_y[k];
		end else if (pick < 85) begin
			x = $urandom_range(0, SCREEN_W - 1);
			y = $urandom_range(0, SCREEN_H - 1);
		end else begin
			// whole signed coordinate range, mostly off screen
			x = int'($urandom_range(0, 2047)) - 1024;
			y = int'($urandom_range(0, 2047)) - 1024;
		end

		// a colour read must hit a pixel that has been written, or miss the screen
		if (op == OP_READ && on_screen(x, y) && !color_mem.exists(y * SCREEN_W + x)) begin
			if (written_px.size() > 0) begin
				k = written_px[$urandom_range(0, written_px.size() - 1)];
				x = k % SCREEN_W;
				y = k / SCREEN_W;
			end else begin
				x = -3;
			end
		end

		// mostly -1.0..1.0, sometimes the full 18-bit field
		if ($urandom_range(0, 9) < 2)
			z = int'($urandom_range(0, 262143)) - 131072;
		else
			z = int'($urandom_range(0, 131072)) - 65536;

		return make_word(op, x, y, z, $urandom_range(0, 255), $urandom_range(0, 255),
			$urandom_range(0, 255));
	endfunction

	// ---------------------------------------------------------------
	// Sender. Called right after a rising edge; returns right after the edge
	// that took the word, or after the gap that follows it. valid stays high
	// in a burst so the next call replaces the word; a gap lowers it for a while.
	// ---------------------------------------------------------------
	task automatic send_frag(frag_word_t w);
		pixel_result_t due;
		frag_ch.valid      <= 1'b1;
		frag_ch.op         <= w.op;
		frag_ch.x_coord    <= w.x_coord;
		frag_ch.y_coord    <= w.y_coord;
		frag_ch.frag_depth <= w.frag_depth;
		frag_ch.red_in     <= w.red;
		frag_ch.green_in   <= w.green;
		frag_ch.blue_in    <= w.blue;
		do
			@(posedge clk);
		while (!frag_ch.ready);
		due         = apply_pixel_op(w);
		due_results = {due_results, due};

		if (burst_left > 0) begin
			burst_left--;
		end else begin
			frag_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			// now and then a long burst with no gaps at all
			burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(20, 60)
				: $urandom_range(0, 8);
		end
	endtask

	task automatic run_random(int count);
		repeat (count) send_frag(random_word());
	endtask

	// stop offering and wait until every predicted result has been seen
	task automatic drain_results();
		if (frag_ch.valid)
			frag_ch.valid <= 1'b0;
		while (due_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [REG_IDX_W-1:0] idx, int value);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_idx   <= idx;
		cfg_wdata <= REG_DATA_W'(value);
		@(posedge clk);
		cfg_we    <= 1'b0;
		case (idx)
			REG_VIEWPORT_X: vp_x     = value & 10'h3FF;
			REG_VIEWPORT_Y: vp_y     = value & 10'h3FF;
			REG_VIEWPORT_W: vp_w     = value & 11'h7FF;
			REG_VIEWPORT_H: vp_h     = value & 11'h7FF;
			REG_DEPTH_TEST: depth_on = value[0];
			default: ;
		endcase
	endtask

	// hot pixels: the two corners of the viewport's on-screen part plus random ones inside it
	task automatic choose_hot_pixels();
		int lo_x, hi_x, lo_y, hi_y;
		lo_x = vp_x;
		lo_y = vp_y;
		hi_x = (vp_x + vp_w < SCREEN_W ? vp_x + vp_w : SCREEN_W) - 1;
		hi_y = (vp_y + vp_h < SCREEN_H ? vp_y + vp_h : SCREEN_H) - 1;
		if (lo_x > hi_x || lo_y > hi_y) begin
			// nothing of the screen is inside; aim at the whole screen
			lo_x = 0;
			lo_y = 0;
			hi_x = SCREEN_W - 1;
			hi_y = SCREEN_H - 1;
		end
		hot_x[0] = lo_x;
		hot_y[0] = lo_y;
		hot_x[1] = hi_x;
		hot_y[1] = hi_y;
		for (int i = 2; i < HOT_N; i++) begin
			hot_x[i] = $urandom_range(lo_x, hi_x);
			hot_y[i] = $urandom_range(lo_y, hi_y);
		end
	endtask

	// registers only change with the pipe empty
	task automatic configure(int x, int y, int w, int h, bit dt);
		drain_results();
		write_reg(REG_VIEWPORT_X, x);
		write_reg(REG_VIEWPORT_Y, y);
		write_reg(REG_VIEWPORT_W, w);
		write_reg(REG_VIEWPORT_H, h);
		write_reg(REG_DEPTH_TEST, dt);
		choose_hot_pixels();
	endtask

	// ---------------------------------------------------------------
	// Tests
	// ---------------------------------------------------------------

	// reset registers: full 640x480 viewport, depth test on
	task automatic test_directed_basics();
		send_frag(make_word(OP_READ, -1024, -1024, 0, 0, 0, 0));          // read off screen
		send_frag(make_word(OP_WRITE, 0, 0, 0, 255, 0, 0));
		send_frag(make_word(OP_WRITE, 639, 479, -65536, 255, 255, 255));  // far corner, nearest
		send_frag(make_word(OP_WRITE, 0, 0, 0, 0, 0, 255));               // equal depth, dropped
		send_frag(make_word(OP_WRITE, 0, 0, -1, 0, 255, 0));              // one below, lands
		send_frag(make_word(OP_READ, 0, 0, 0, 0, 0, 0));
		send_frag(make_word(OP_READ, 639, 479, 0, 0, 0, 0));
		// off each screen edge, mostly just past it
		send_frag(make_word(OP_WRITE, 640, 0, -100, 1, 2, 3));
		send_frag(make_word(OP_WRITE, 0, 480, -100, 1, 2, 3));
		send_frag(make_word(OP_WRITE, 1023, 1023, -100, 1, 2, 3));
		send_frag(make_word(OP_WRITE, -1, 5, -100, 1, 2, 3));
		send_frag(make_word(OP_READ, 1023, -1, 0, 0, 0, 0));
		send_frag(make_word(OP_CLEAR, 0, 0, 0, 0, 0, 0));
		send_frag(make_word(OP_CLEAR, -1, -1, 0, 0, 0, 0));               // clear off screen
		send_frag(make_word(OP_WRITE, 0, 0, 65535, 10, 20, 30));          // just under far
		send_frag(make_word(OP_WRITE, 5, 5, 65536, 1, 1, 1));             // equal to far
		send_frag(make_word(OP_WRITE, 6, 6, 131071, 1, 1, 1));            // beyond far
		send_frag(make_word(OP_WRITE, 5, 5, -131072, 255, 0, 255));       // most negative depth
		send_frag(make_word(OP_WRITE, 5, 5, -131072, 0, 255, 0));
		send_frag(make_word(OP_UNUSED, 0, 0, -131072, 255, 255, 255));
		send_frag(make_word(OP_READ, 0, 0, 0, 0, 0, 0));
		send_frag(make_word(OP_READ, 5, 5, 0, 0, 0, 0));
	endtask

	task automatic test_random_default();
		run_random(150);
	endtask

	task automatic test_small_viewport();
		configure(100, 50, 200, 100, 1'b1);
		// one pixel outside each viewport edge, then two opposite inner corners
		send_frag(make_word(OP_WRITE, 99, 50, -200, 9, 9, 9));
		send_frag(make_word(OP_WRITE, 100, 49, -200, 9, 9, 9));
		send_frag(make_word(OP_WRITE, 300, 50, -200, 9, 9, 9));
		send_frag(make_word(OP_WRITE, 100, 150, -200, 9, 9, 9));
		send_frag(make_word(OP_WRITE, 299, 149, -200, 40, 50, 60));
		send_frag(make_word(OP_WRITE, 100, 50, -200, 70, 80, 90));
		send_frag(make_word(OP_CLEAR, 0, 0, 0, 0, 0, 0));                 // outside viewport
		send_frag(make_word(OP_READ, 299, 149, 0, 0, 0, 0));
		run_random(100);
	endtask

	// depth store neither compared nor updated by writes; viewport covers the screen
	task automatic test_depth_test_off();
		configure(0, 0, 1024, 1024, 1'b0);
		send_frag(make_word(OP_WRITE, 0, 0, 131071, 11, 22, 33));
		send_frag(make_word(OP_WRITE, 0, 0, 131071, 44, 55, 66));
		send_frag(make_word(OP_CLEAR, 1, 1, 0, 0, 0, 0));
		run_random(90);
	endtask

	// zero width, zero height, and a viewport that starts past the screen
	task automatic test_empty_viewport();
		configure(0, 0, 0, 480, 1'b1);
		run_random(20);
		configure(0, 0, 640, 0, 1'b1);
		run_random(20);
		configure(1023, 1023, 1024, 1024, 1'b1);
		run_random(20);
	endtask

	// output side refuses for a long stretch while words keep coming,
	// so the pipe fills and frag.ready must drop
	task automatic test_output_backpressure();
		configure(0, 0, 640, 480, 1'b1);
		hold_tog <= ~hold_tog;
		run_random(60);
	endtask

	// viewport ending exactly at the screen's last column and last row
	task automatic test_random_restored();
		configure(320, 240, 320, 240, 1'b1);
		run_random(80);
	endtask

	// ---------------------------------------------------------------
	// Main sequence
	// ---------------------------------------------------------------
	initial begin
		arst_n        = 1'b0;
		cfg_we        = 1'b0;
		cfg_idx       = '0;
		cfg_wdata     = '0;
		frag_ch.valid = 1'b0;
		frag_ch.op    = OP_WRITE;
		frag_ch.x_coord    = '0;
		frag_ch.y_coord    = '0;
		frag_ch.frag_depth = '0;
		frag_ch.red_in     = '0;
		frag_ch.green_in   = '0;
		frag_ch.blue_in    = '0;
		fail_count = 0;
		burst_left = 0;
		hold_tog   = 1'b0;
		// predictor mirrors the reset register values
		vp_x     = 0;
		vp_y     = 0;
		vp_w     = SCREEN_W;
		vp_h     = SCREEN_H;
		depth_on = 1'b1;
		choose_hot_pixels();

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// the first word waits out the depth RAM sweep via frag.ready
		test_directed_basics();
		test_random_default();
		test_small_viewport();
		test_depth_test_off();
		test_empty_viewport();
		test_output_backpressure();
		test_random_restored();

		drain_results();
		if (due_results.size() != 0) begin
			$error("%0d results never arrived", due_results.size());
			fail_count++;
		end
		if (fail_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	// ---------------------------------------------------------------
	// Receiver: stall pattern that changes every so often (all-ones now and
	// then for unbroken stretches), plus the long hold on request.
	// ---------------------------------------------------------------
	initial begin : result_sink
		int          hold_left;
		int          pat_age;
		int          phase;
		bit          hold_seen;
		logic [15:0] stall_pat;

		hold_left = 0;
		pat_age   = 0;
		phase     = 0;
		hold_seen = 1'b0;
		stall_pat = '1;
		res_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_tog != hold_seen) begin
				hold_seen = hold_tog;
				hold_left = HOLD_CYCLES;
			end
			if (pat_age == 0) begin
				pat_age = $urandom_range(16, 128);
				case ($urandom_range(0, 3))
					0: stall_pat = '1;
					1: stall_pat = 16'($urandom);
					2: stall_pat = 16'($urandom | $urandom);
					default: stall_pat = 16'($urandom & $urandom);
				endcase
				stall_pat[0] = 1'b1;
			end else begin
				pat_age--;
			end
			phase = (phase + 1) % 16;
			if (hold_left > 0) begin
				hold_left--;
				res_ch.ready <= 1'b0;
			end else begin
				res_ch.ready <= stall_pat[phase];
			end
		end
	end

	// ---------------------------------------------------------------
	// Result check: every taken word against the oldest prediction
	// ---------------------------------------------------------------
	always @(posedge clk) begin : result_check
		pixel_result_t due;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (due_results.size() == 0) begin
				$error("result word with nothing expected");
				fail_count++;
			end else begin
				due = due_results.pop_front();
				if (res_ch.written !== due.written) begin
					$error("written: expected %0d, actual %0d", due.written, res_ch.written);
					fail_count++;
				end
				if (res_ch.red_out !== due.red) begin
					$error("red_out: expected %0d, actual %0d", due.red, res_ch.red_out);
					fail_count++;
				end
				if (res_ch.green_out !== due.green) begin
					$error("green_out: expected %0d, actual %0d", due.green, res_ch.green_out);
					fail_count++;
				end
				if (res_ch.blue_out !== due.blue) begin
					$error("blue_out: expected %0d, actual %0d", due.blue, res_ch.blue_out);
					fail_count++;
				end
			end
		end
	end

	// ---------------------------------------------------------------
	// Watchdog: cycles with no word moving on either channel
	// ---------------------------------------------------------------
	int idle_cycles = 0;

	always @(posedge clk) begin
		if ((frag_ch.valid && frag_ch.ready) || (res_ch.valid && res_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$error("no progress for %0d cycles", STALL_LIMIT);
			$display("Some tests failed");
			$finish;
		end
	end

endmodule
